[hw/rtl/tspi_pkg.sv]
package tspi_pkg;

  // Source store depth per plane
  localparam int MAX_PLANE_BYTES = 512;
  localparam int PLANE_AW        = $clog2(MAX_PLANE_BYTES);

  // Box dimension nibbles
  localparam logic [7:0] BOX_W_MASK = 8'b0000_1111;
  localparam logic [7:0] BOX_H_MASK = 8'b1111_0000;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_TILES  = 3'd0,
    CFG_HEIGHT_TILES = 3'd1,
    CFG_TILE_BYTES   = 3'd2,
    CFG_BOX_DIMS     = 3'd3,
    CFG_CANVAS_BYTES = 3'd4
  } cfg_reg_t;

  localparam logic [3:0] RST_WIDTH_TILES  = 4'd7;
  localparam logic [3:0] RST_HEIGHT_TILES = 4'd7;
  localparam logic [4:0] RST_TILE_BYTES   = 5'd8;
  localparam logic [7:0] RST_BOX_DIMS     = 8'd119;
  localparam logic [9:0] RST_CANVAS_BYTES = 10'd392;

  // Request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic       plane;
    logic [9:0] index;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       bad_box;
    logic       out_of_range;
  } out_t;

endpackage

[hw/rtl/tspi_ram.sv]
module tspi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/tile_sprite_center_and_plane_interleave.sv]
// A read request's result reaches out_data through the address pipeline and the output register.
// Throughput: one request per cycle unless in_stall is high; the address path is an 8-stage
// pipeline whose stages capture, multiply, check ranges or take two restoring divide steps,
// ending in one read of the plane store. Write requests travel the same pipeline and give no result.
// Reset (rst_n low, synchronous) clears the pipeline valids and reloads the registers;
// source stores are not cleared.
module tile_sprite_center_and_plane_interleave
  import tspi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Per-request pipeline record; each stage fills in more of it
  typedef struct packed {
    logic        is_read;
    logic        sel;       // plane picked
    logic [9:0]  idx;
    logic [7:0]  din;
    logic        bad;
    logic        oor;
    logic        zero;      // byte lies outside the box
    logic [3:0]  bw;
    logic [7:0]  colbytes;  // H*B
    logic [7:0]  hrow;      // H*x + (H-bh)
    logic [7:0]  boxcol;    // bh*B
    logic [12:0] base;
    logic [11:0] bwcol;     // bw*H*B
    logic [8:0]  rem;
    logic [3:0]  quo;
    logic [11:0] addr;
  } pipe_t;

  logic [3:0] width_tiles_r, height_tiles_r;
  logic [4:0] tile_bytes_r;
  logic [7:0] box_dims_r;
  logic [9:0] canvas_bytes_r;

  pipe_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r;
  pipe_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt;
  logic [8:1] vld_r;
  logic       adv;
  logic       out_valid_r;
  out_t       out_data_r, out_data_nxt;
  logic       we0, we1, wr_ok;
  logic [7:0] rd0, rd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_tiles_r  <= RST_WIDTH_TILES;
      height_tiles_r <= RST_HEIGHT_TILES;
      tile_bytes_r   <= RST_TILE_BYTES;
      box_dims_r     <= RST_BOX_DIMS;
      canvas_bytes_r <= RST_CANVAS_BYTES;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_WIDTH_TILES:  width_tiles_r  <= cfg_data[3:0];
        CFG_HEIGHT_TILES: height_tiles_r <= cfg_data[3:0];
        CFG_TILE_BYTES:   tile_bytes_r   <= cfg_data[4:0];
        CFG_BOX_DIMS:     box_dims_r     <= cfg_data[7:0];
        CFG_CANVAS_BYTES: canvas_bytes_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the output register holds an untaken result
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 1: capture request
  always_comb begin
    s1_nxt         = s1_r;
    s1_nxt.is_read = (in_data.opcode == OP_READ);
    s1_nxt.sel     = (in_data.opcode == OP_READ) ? in_data.index[0] : in_data.plane;
    s1_nxt.idx     = in_data.index;
    s1_nxt.din     = in_data.data_in;
  end

  // Stage 2: flags, box column, small products
  always_comb begin
    logic [3:0] bw, bh;
    logic [4:0] span;
    logic [3:0] x;
    logic [7:0] hx;
    bw     = box_dims_r[3:0] & BOX_W_MASK[3:0];
    bh     = 4'((box_dims_r & BOX_H_MASK) >> 4);
    span   = {1'b0, width_tiles_r} - {1'b0, bw} + 5'd1;
    x      = span[4:1];
    hx     = {4'b0, height_tiles_r} * {4'b0, x};
    s2_nxt = s1_r;
    s2_nxt.bad      = (bw > width_tiles_r) || (bh > height_tiles_r);
    s2_nxt.oor      = {1'b0, s1_r.idx} >= {canvas_bytes_r, 1'b0};
    s2_nxt.zero     = (bw == '0) || (bh == '0) || (height_tiles_r == '0) ||
                      (tile_bytes_r == '0);
    s2_nxt.bw       = bw;
    s2_nxt.colbytes = {4'b0, height_tiles_r} * {3'b0, tile_bytes_r};
    s2_nxt.boxcol   = {4'b0, bh} * {3'b0, tile_bytes_r};
    s2_nxt.hrow     = hx + 8'(height_tiles_r - bh);
  end

  // Stage 3: box origin and box extent in bytes
  always_comb begin
    s3_nxt       = s2_r;
    s3_nxt.base  = {8'b0, tile_bytes_r} * {5'b0, s2_r.hrow};
    s3_nxt.bwcol = {8'b0, s2_r.bw} * {4'b0, s2_r.colbytes};
  end

  // Stage 4: offset into the box, column range check
  always_comb begin
    logic [8:0] p;
    logic       below;
    p      = s3_r.idx[9:1];
    below  = {4'b0, p} < s3_r.base;
    s4_nxt = s3_r;
    s4_nxt.rem  = p - s3_r.base[8:0];
    s4_nxt.zero = s3_r.zero || below || ({3'b0, s4_nxt.rem} >= s3_r.bwcol);
  end

  // Stage 5: column divide, quotient bits 3 and 2
  always_comb begin
    logic [11:0] r, t;
    s5_nxt = s4_r;
    r = {3'b0, s4_r.rem};
    t = {4'b0, s4_r.colbytes} << 3;
    s5_nxt.quo[3] = (r >= t);
    if (s5_nxt.quo[3]) r = r - t;
    t = {4'b0, s4_r.colbytes} << 2;
    s5_nxt.quo[2] = (r >= t);
    if (s5_nxt.quo[2]) r = r - t;
    s5_nxt.rem = r[8:0];
  end

  // Stage 6: column divide, quotient bits 1 and 0
  always_comb begin
    logic [11:0] r, t;
    s6_nxt = s5_r;
    r = {3'b0, s5_r.rem};
    t = {4'b0, s5_r.colbytes} << 1;
    s6_nxt.quo[1] = (r >= t);
    if (s6_nxt.quo[1]) r = r - t;
    t = {4'b0, s5_r.colbytes};
    s6_nxt.quo[0] = (r >= t);
    if (s6_nxt.quo[0]) r = r - t;
    s6_nxt.rem = r[8:0];
  end

  // Stage 7: source address, row range and store range checks
  always_comb begin
    s7_nxt      = s6_r;
    s7_nxt.addr = ({8'b0, s6_r.quo} * {4'b0, s6_r.boxcol}) + {3'b0, s6_r.rem};
    s7_nxt.zero = s6_r.zero || ({3'b0, s6_r.rem} >= {4'b0, s6_r.boxcol}) ||
                  (32'(s7_nxt.addr) >= MAX_PLANE_BYTES);
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[7:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
      s8_r <= s7_r;
    end
  end

  // Source stores: writes and reads both happen at stage 7, in request order
  assign wr_ok = adv && vld_r[7] && !s7_r.is_read && (32'(s7_r.idx) < MAX_PLANE_BYTES);
  assign we0   = wr_ok && !s7_r.sel;
  assign we1   = wr_ok && s7_r.sel;

  tspi_ram #(.WIDTH(8), .DEPTH(MAX_PLANE_BYTES)) u_plane0 (
    .clk   (clk),
    .we    (we0),
    .waddr (PLANE_AW'(s7_r.idx)),
    .wdata (s7_r.din),
    .re    (adv),
    .raddr (s7_r.addr[PLANE_AW-1:0]),
    .rdata (rd0)
  );

  tspi_ram #(.WIDTH(8), .DEPTH(MAX_PLANE_BYTES)) u_plane1 (
    .clk   (clk),
    .we    (we1),
    .waddr (PLANE_AW'(s7_r.idx)),
    .wdata (s7_r.din),
    .re    (adv),
    .raddr (s7_r.addr[PLANE_AW-1:0]),
    .rdata (rd1)
  );

  // Output register: pick plane, force zero outside the box or for a bad box or out-of-range index
  always_comb begin
    out_data_nxt.bad_box      = s8_r.bad;
    out_data_nxt.out_of_range = s8_r.oor;
    if (s8_r.bad || s8_r.oor || s8_r.zero) begin
      out_data_nxt.data_out = '0;
    end else begin
      out_data_nxt.data_out = s8_r.sel ? rd1 : rd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[8] && s8_r.is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Reset empties the pipeline and the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && (vld_r == '0)))
    else $error("pipeline not empty after reset");

  // A held output freezes every stage valid
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during output stall");

  // Write requests never make a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[8] && !s8_r.is_read) |=> !out_valid_r)
    else $error("write request produced a result");

  // Flagged reads return zero data
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.bad_box || out_data_r.out_of_range))
      |-> (out_data_r.data_out == '0))
    else $error("flagged read returned nonzero data");
`endif

endmodule
